// ----- rtl/max_heap_priority_queue_defines.svh -----
// assertion macros used by the priority queue rtl
`ifndef MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// property that must hold on every clock out of reset
`define MHPQ_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// same-cycle implication checked out of reset
`define MHPQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mhpq_pkg.sv -----
// shared constants, types and helpers for the max-heap priority queue
package mhpq_pkg;

    localparam int HEAP_DEPTH   = 1024;
    localparam int VALUE_WIDTH  = 32;
    localparam int VALUE_PORT_W = 32;
    localparam int COUNT_PORT_W = 11;
    localparam int NUM_LEVELS   = $clog2(HEAP_DEPTH + 1);
    localparam int NODE_W       = NUM_LEVELS;
    localparam int CNT_W        = NUM_LEVELS;
    localparam int LVL_W        = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;

    typedef logic signed [VALUE_WIDTH-1:0] store_t;
    typedef logic [NODE_W-1:0]             node_t;
    typedef logic [CNT_W-1:0]              count_t;
    typedef logic [LVL_W-1:0]              level_t;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_DEL_MAX = 2'd1,
        OP_DEL_VAL = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_LAST_RD,
        S_LAST_GET,
        S_SU_RD,
        S_SU_CMP,
        S_SD_RD_L,
        S_SD_RD_R,
        S_SD_CMP,
        S_FINISH
    } state_t;

    // access broadcast down the row of level cells, node is 1-based
    typedef struct packed {
        logic   rd;
        logic   wr;
        node_t  node;
        store_t data;
    } mem_cmd_t;

    // access a level cell hands to its own memory
    typedef struct packed {
        logic   rd;
        logic   wr;
        node_t  offset;
        store_t data;
    } ram_req_t;

    // number of heap slots that live on one tree level
    function automatic int level_depth(input int lvl);
        int first;
        int rest;
        first = 1 << lvl;
        rest  = HEAP_DEPTH + 1 - first;
        return (first < rest) ? first : rest;
    endfunction

    // address width of a level memory
    function automatic int level_aw(input int lvl);
        int d;
        d = level_depth(lvl);
        return (d > 1) ? $clog2(d) : 1;
    endfunction

endpackage

// ----- rtl/mhpq_ram.sv -----
// generic single-port ram with registered read data
module mhpq_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic             wr_en,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// ----- rtl/mhpq_level_cell.sv -----
// one tree level: decodes its node range and joins the read-data chain
module mhpq_level_cell
    import mhpq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  level_t   level,
    input  mem_cmd_t cmd,
    input  store_t   chain_in,
    input  store_t   ram_rdata,
    output ram_req_t ram_req,
    output store_t   chain_out,
    output logic     sel
);

    node_t base;
    logic  hit_reg;
    logic  hit_next;

    // this level holds nodes base .. 2*base-1
    always_comb
    begin
        base         = node_t'(1) << level;
        sel          = (cmd.rd | cmd.wr) && (cmd.node >= base) && ((cmd.node >> 1) < base);
        ram_req.rd   = sel & cmd.rd;
        ram_req.wr   = sel & cmd.wr;
        ram_req.offset = cmd.node - base;
        ram_req.data = cmd.data;
        hit_next     = sel & cmd.rd;
    end

    // remember which level answers the read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    // pass read data along the row
    assign chain_out = chain_in | (hit_reg ? ram_rdata : store_t'(0));

endmodule

// ----- rtl/max_heap_priority_queue.sv -----
// Binary max-heap priority queue built as a row of tree-level cells, each with its
// own memory. One item is processed at a time and the controller makes at most one
// memory access per cycle, so the time an item takes depends on how far entries move.
// Insert puts the new value in the next free slot and sifts it up past smaller parents;
// delete-max moves the last entry to the root and sifts it down past larger children;
// delete-by-value first scans the entries in index order at one per cycle, then fills
// the found slot from the last one and sifts up or down as above. A finished item
// waits in an output register so the next item can be taken.
`include "max_heap_priority_queue_defines.svh"

module max_heap_priority_queue
    import mhpq_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     opcode,
    input  logic signed [VALUE_PORT_W-1:0] value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [VALUE_PORT_W-1:0] result_value,
    output logic [1:0]                     status,
    output logic [COUNT_PORT_W-1:0]        entry_count
);

    state_t   state_reg, state_next;
    count_t   count_reg, count_next;
    node_t    pos_reg, pos_next;
    node_t    scan_reg, scan_next;
    node_t    chk_reg, chk_next;
    logic     pend_reg, pend_next;
    logic     moved_reg, moved_next;
    logic     r_ok_reg, r_ok_next;
    op_t      op_reg, op_next;
    status_t  st_reg, st_next;
    store_t   x_reg, x_next;
    store_t   val_reg, val_next;
    store_t   max_reg, max_next;
    store_t   lv_reg, lv_next;
    store_t   top_reg, top_next;

    logic     out_valid_reg;
    logic     out_load;
    store_t   res_reg;
    status_t  status_reg;
    count_t   cnt_out_reg;

    mem_cmd_t mem_cmd;
    store_t   rd_data;
    store_t   chain [NUM_LEVELS+1];
    logic [NUM_LEVELS-1:0] cell_sel;

    node_t           parent;
    logic [NODE_W:0] lchild;
    logic [NODE_W:0] rchild;
    logic [NODE_W:0] count_ext;
    store_t          big_val;
    node_t           big_node;
    store_t          fin_val;

    // row of level cells, read data flows from level 0 to the last level
    assign chain[0] = store_t'(0);
    assign rd_data  = chain[NUM_LEVELS];

    for (genvar g = 0; g < NUM_LEVELS; g++)
    begin : g_level
        localparam int LDEPTH = level_depth(g);
        localparam int LAW    = level_aw(g);

        ram_req_t req;
        store_t   rdata;

        mhpq_level_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .level     (level_t'(g)),
            .cmd       (mem_cmd),
            .chain_in  (chain[g]),
            .ram_rdata (rdata),
            .ram_req   (req),
            .chain_out (chain[g+1]),
            .sel       (cell_sel[g])
        );

        mhpq_ram #(
            .DEPTH (LDEPTH),
            .WIDTH (VALUE_WIDTH)
        ) u_ram (
            .clk   (clk),
            .rd_en (req.rd),
            .wr_en (req.wr),
            .addr  (req.offset[LAW-1:0]),
            .wdata (req.data),
            .rdata (rdata)
        );
    end

    // result of the item in flight
    assign fin_val = ((op_reg == OP_DEL_MAX) && (st_reg == ST_OK)) ? max_reg :
                     ((count_reg == '0) ? store_t'(0) : top_reg);

    // sequencer: next state, memory access and item result
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        scan_next  = scan_reg;
        chk_next   = chk_reg;
        pend_next  = pend_reg;
        moved_next = moved_reg;
        r_ok_next  = r_ok_reg;
        op_next    = op_reg;
        st_next    = st_reg;
        x_next     = x_reg;
        val_next   = val_reg;
        max_next   = max_reg;
        lv_next    = lv_reg;
        top_next   = top_reg;
        mem_cmd    = '0;
        in_ready   = 1'b0;
        out_load   = 1'b0;

        parent    = pos_reg >> 1;
        lchild    = {pos_reg, 1'b0};
        rchild    = {pos_reg, 1'b1};
        count_ext = {1'b0, count_reg};
        big_val   = x_reg;
        big_node  = pos_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next    = op_t'(opcode);
                    val_next   = VALUE_WIDTH'(value);
                    st_next    = ST_OK;
                    moved_next = 1'b0;
                    unique case (op_t'(opcode))
                        OP_INSERT:
                        begin
                            if (count_reg >= CNT_W'(HEAP_DEPTH))
                            begin
                                st_next    = ST_FULL;
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                                pos_next   = NODE_W'(count_reg) + 1'b1;
                                x_next     = VALUE_WIDTH'(value);
                                state_next = S_SU_RD;
                            end
                        end
                        OP_DEL_MAX:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next    = ST_EMPTY;
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                max_next   = top_reg;
                                count_next = count_reg - 1'b1;
                                pos_next   = NODE_W'(1);
                                state_next = (count_reg == CNT_W'(1)) ? S_FINISH : S_LAST_RD;
                            end
                        end
                        OP_DEL_VAL:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next    = ST_EMPTY;
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                scan_next  = NODE_W'(1);
                                pend_next  = 1'b0;
                                state_next = S_SEARCH;
                            end
                        end
                        OP_NOP:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            // scan in index order, one read issued and one compare per cycle
            S_SEARCH:
            begin
                if (pend_reg && (rd_data == val_reg))
                begin
                    pend_next  = 1'b0;
                    count_next = count_reg - 1'b1;
                    pos_next   = chk_reg;
                    state_next = (chk_reg == NODE_W'(count_reg)) ? S_FINISH : S_LAST_RD;
                end
                else if (scan_reg <= NODE_W'(count_reg))
                begin
                    mem_cmd.rd  = 1'b1;
                    mem_cmd.node = scan_reg;
                    pend_next   = 1'b1;
                    chk_next    = scan_reg;
                    scan_next   = scan_reg + 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    st_next    = ST_NOTFOUND;
                    state_next = S_FINISH;
                end
            end

            // fetch the entry that leaves the last slot
            S_LAST_RD:
            begin
                mem_cmd.rd   = 1'b1;
                mem_cmd.node = NODE_W'(count_reg) + 1'b1;
                state_next   = S_LAST_GET;
            end

            S_LAST_GET:
            begin
                x_next     = rd_data;
                state_next = (op_reg == OP_DEL_VAL) ? S_SU_RD : S_SD_RD_L;
            end

            // sift up: read parent
            S_SU_RD:
            begin
                if (pos_reg == NODE_W'(1))
                begin
                    if ((op_reg == OP_DEL_VAL) && !moved_reg)
                    begin
                        state_next = S_SD_RD_L;
                    end
                    else
                    begin
                        mem_cmd.wr   = 1'b1;
                        mem_cmd.node = pos_reg;
                        mem_cmd.data = x_reg;
                        state_next   = S_FINISH;
                    end
                end
                else
                begin
                    mem_cmd.rd   = 1'b1;
                    mem_cmd.node = parent;
                    state_next   = S_SU_CMP;
                end
            end

            // sift up: move parent down or settle
            S_SU_CMP:
            begin
                if (x_reg > rd_data)
                begin
                    mem_cmd.wr   = 1'b1;
                    mem_cmd.node = pos_reg;
                    mem_cmd.data = rd_data;
                    pos_next     = parent;
                    moved_next   = 1'b1;
                    state_next   = S_SU_RD;
                end
                else if ((op_reg == OP_DEL_VAL) && !moved_reg)
                begin
                    state_next = S_SD_RD_L;
                end
                else
                begin
                    mem_cmd.wr   = 1'b1;
                    mem_cmd.node = pos_reg;
                    mem_cmd.data = x_reg;
                    state_next   = S_FINISH;
                end
            end

            // sift down: read left child or settle at a leaf
            S_SD_RD_L:
            begin
                if (lchild > count_ext)
                begin
                    mem_cmd.wr   = 1'b1;
                    mem_cmd.node = pos_reg;
                    mem_cmd.data = x_reg;
                    state_next   = S_FINISH;
                end
                else
                begin
                    mem_cmd.rd   = 1'b1;
                    mem_cmd.node = lchild[NODE_W-1:0];
                    r_ok_next    = (rchild <= count_ext);
                    state_next   = S_SD_RD_R;
                end
            end

            // sift down: keep left child, read right child
            S_SD_RD_R:
            begin
                lv_next = rd_data;
                if (r_ok_reg)
                begin
                    mem_cmd.rd   = 1'b1;
                    mem_cmd.node = rchild[NODE_W-1:0];
                end
                state_next = S_SD_CMP;
            end

            // sift down: pick the largest, left wins a tie
            S_SD_CMP:
            begin
                if (lv_reg > x_reg)
                begin
                    big_val  = lv_reg;
                    big_node = lchild[NODE_W-1:0];
                end
                if (r_ok_reg && (rd_data > big_val))
                begin
                    big_val  = rd_data;
                    big_node = rchild[NODE_W-1:0];
                end
                mem_cmd.wr   = 1'b1;
                mem_cmd.node = pos_reg;
                mem_cmd.data = big_val;
                if (big_node == pos_reg)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    pos_next   = big_node;
                    state_next = S_SD_RD_L;
                end
            end

            // hand the result to the output register
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // track the root value
        if (mem_cmd.wr && (mem_cmd.node == NODE_W'(1)))
        begin
            top_next = mem_cmd.data;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        scan_reg  <= scan_next;
        chk_reg   <= chk_next;
        moved_reg <= moved_next;
        r_ok_reg  <= r_ok_next;
        op_reg    <= op_next;
        st_reg    <= st_next;
        x_reg     <= x_next;
        val_reg   <= val_next;
        max_reg   <= max_next;
        lv_reg    <= lv_next;
        top_reg   <= top_next;
        if (out_load)
        begin
            res_reg     <= fin_val;
            status_reg  <= st_reg;
            cnt_out_reg <= count_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = VALUE_PORT_W'(res_reg);
    assign status       = status_reg;
    assign entry_count  = COUNT_PORT_W'(cnt_out_reg);

    // checks
    `MHPQ_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(HEAP_DEPTH), "entry count above depth")
    `MHPQ_ASSERT_ALWAYS(a_one_level, $onehot0(cell_sel), "more than one level cell selected")
    `MHPQ_ASSERT_IMPLY(a_full_count, out_load && (st_reg == ST_FULL), count_reg == CNT_W'(HEAP_DEPTH), "full status with room left")
    `MHPQ_ASSERT_IMPLY(a_sift_pos, state_reg == S_SD_CMP, pos_reg <= NODE_W'(count_reg), "sift position beyond count")

endmodule
